// ===== rtl/kecd_pkg.sv =====
package kecd_pkg;

	// Matrix size covered by the character tables
	localparam logic [3:0] MAP_ROWS = 4'd4;
	localparam logic [3:0] MAP_COLS = 4'd10;

	// Matrix positions of the special keys
	localparam logic [6:0] POS_ALT       = 7'h14;
	localparam logic [6:0] POS_CAPS      = 7'h1C;
	localparam logic [6:0] POS_BACKSPACE = 7'h1D;
	localparam logic [6:0] POS_SPACE     = 7'h1E;

	localparam logic [6:0] CODE_GPIO_MIN = 7'd96;

	localparam logic [6:0] CHAR_SPACE     = 7'h20;
	localparam logic [6:0] CHAR_NEWLINE   = 7'h0A;
	localparam logic [6:0] CHAR_BACKSPACE = 7'h08;
	localparam logic [6:0] CASE_OFFSET    = 7'd32;

	localparam logic [15:0] DEBOUNCE_RESET    = 16'd15000;
	localparam logic [15:0] RELEASE_GAP_RESET = 16'd40000;
	localparam logic [3:0]  ROWS_RESET        = 4'd4;
	localparam logic [3:0]  COLS_RESET        = 4'd10;

	typedef enum logic [1:0] {
		CFG_ROWS        = 2'd0,
		CFG_COLS        = 2'd1,
		CFG_DEBOUNCE    = 2'd2,
		CFG_RELEASE_GAP = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_ALT       = 3'd1,
		KIND_SPACE     = 3'd2,
		KIND_CAPS      = 3'd3,
		KIND_BACKSPACE = 3'd4,
		KIND_ENTER     = 3'd5,
		KIND_CHAR      = 3'd6
	} kind_t;

	typedef struct packed {
		logic [3:0]  rows_in_use;
		logic [3:0]  cols_in_use;
		logic [15:0] space_debounce_us;
		logic [15:0] space_release_gap_us;
	} cfg_t;

	typedef struct packed {
		logic       status;
		logic       event_valid;
		logic [7:0] raw_copy;
		logic       is_press;
		logic [6:0] key_code;
		logic       gpio_event;
		logic [6:0] matrix_position;
		logic [3:0] key_row;
		logic [3:0] key_column;
		logic [2:0] key_kind;
		logic [6:0] character;
	} res_t;

	function automatic logic [6:0] letter_char(input logic [6:0] pos);
		logic [6:0] ch;
		case (pos)
			7'd0:  ch = 7'h71;
			7'd1:  ch = 7'h77;
			7'd2:  ch = 7'h65;
			7'd3:  ch = 7'h72;
			7'd4:  ch = 7'h74;
			7'd5:  ch = 7'h79;
			7'd6:  ch = 7'h75;
			7'd7:  ch = 7'h69;
			7'd8:  ch = 7'h6F;
			7'd9:  ch = 7'h70;
			7'd10: ch = 7'h61;
			7'd11: ch = 7'h73;
			7'd12: ch = 7'h64;
			7'd13: ch = 7'h66;
			7'd14: ch = 7'h67;
			7'd15: ch = 7'h68;
			7'd16: ch = 7'h6A;
			7'd17: ch = 7'h6B;
			7'd18: ch = 7'h6C;
			7'd19: ch = CHAR_NEWLINE;
			7'd21: ch = 7'h7A;
			7'd22: ch = 7'h78;
			7'd23: ch = 7'h63;
			7'd24: ch = 7'h76;
			7'd25: ch = 7'h62;
			7'd26: ch = 7'h6E;
			7'd27: ch = 7'h6D;
			7'd30: ch = CHAR_SPACE;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [6:0] symbol_char(input logic [6:0] pos);
		logic [6:0] ch;
		case (pos)
			7'd0:  ch = 7'h31;
			7'd1:  ch = 7'h32;
			7'd2:  ch = 7'h33;
			7'd3:  ch = 7'h34;
			7'd4:  ch = 7'h35;
			7'd5:  ch = 7'h36;
			7'd6:  ch = 7'h37;
			7'd7:  ch = 7'h38;
			7'd8:  ch = 7'h39;
			7'd9:  ch = 7'h30;
			7'd10: ch = 7'h2A;
			7'd11: ch = 7'h2F;
			7'd12: ch = 7'h2B;
			7'd13: ch = 7'h2D;
			7'd14: ch = 7'h3D;
			7'd15: ch = 7'h3A;
			7'd16: ch = 7'h27;
			7'd17: ch = 7'h22;
			7'd18: ch = 7'h40;
			7'd21: ch = 7'h5F;
			7'd22: ch = 7'h24;
			7'd23: ch = 7'h3B;
			7'd24: ch = 7'h3F;
			7'd25: ch = 7'h21;
			7'd26: ch = 7'h2C;
			7'd27: ch = 7'h2E;
			7'd30: ch = CHAR_SPACE;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/kecd_evt_if.sv =====
interface kecd_evt_if;
	logic        valid;
	logic        ready;
	logic        event_pending;
	logic [7:0]  raw_event;
	logic [47:0] now_us;

	modport source (output valid, output event_pending, output raw_event, output now_us,
		input ready);
	modport sink (input valid, input event_pending, input raw_event, input now_us,
		output ready);
endinterface

// ===== rtl/kecd_res_if.sv =====
interface kecd_res_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       event_valid;
	logic [7:0] raw_copy;
	logic       is_press;
	logic [6:0] key_code;
	logic       gpio_event;
	logic [6:0] matrix_position;
	logic [3:0] key_row;
	logic [3:0] key_column;
	logic [2:0] key_kind;
	logic [6:0] character;

	modport source (output valid, output status, output event_valid, output raw_copy,
		output is_press, output key_code, output gpio_event, output matrix_position,
		output key_row, output key_column, output key_kind, output character,
		input ready);
	modport sink (input valid, input status, input event_valid, input raw_copy,
		input is_press, input key_code, input gpio_event, input matrix_position,
		input key_row, input key_column, input key_kind, input character,
		output ready);
endinterface

// ===== rtl/kecd_cfg_regs.sv =====
module kecd_cfg_regs
	import kecd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use          <= ROWS_RESET;
			cfg_q.cols_in_use          <= COLS_RESET;
			cfg_q.space_debounce_us    <= DEBOUNCE_RESET;
			cfg_q.space_release_gap_us <= RELEASE_GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_ROWS:        cfg_q.rows_in_use          <= cfg_wdata[3:0];
				CFG_COLS:        cfg_q.cols_in_use          <= cfg_wdata[3:0];
				CFG_DEBOUNCE:    cfg_q.space_debounce_us    <= cfg_wdata;
				CFG_RELEASE_GAP: cfg_q.space_release_gap_us <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/kecd_core.sv =====
module kecd_core
	import kecd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	kecd_evt_if.sink   events,
	input  logic       down_ready,
	output logic       res_valid,
	output res_t       res
);

	logic        v_s1;
	logic        pending_s1;
	logic [7:0]  raw_s1;
	logic [47:0] now_s1;

	logic        sym_q, caps_q;
	logic [47:0] last_space_q;
	logic        sym_d, caps_d;
	logic [47:0] last_space_d;

	logic        adv;
	logic        press;
	logic [6:0]  code;
	logic [6:0]  pos;
	logic [14:0] row_prod;
	logic [3:0]  row;
	logic [6:0]  col_full;
	logic [3:0]  col;
	logic [15:0] gap;
	logic        space_ok;
	logic [6:0]  rom_ch;
	logic        in_map;
	res_t        r;

	assign adv          = v_s1 & down_ready;
	assign events.ready = !v_s1 | down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (events.ready) begin
			v_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			pending_s1 <= events.event_pending;
			raw_s1     <= events.raw_event;
			now_s1     <= events.now_us;
		end
	end

	// Mode state commits only when the beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q        <= 1'b0;
			caps_q       <= 1'b0;
			last_space_q <= '0;
		end else if (adv) begin
			sym_q        <= sym_d;
			caps_q       <= caps_d;
			last_space_q <= last_space_d;
		end
	end

	always_comb begin
		press    = raw_s1[7];
		code     = raw_s1[6:0];
		pos      = code - 7'd1;
		// divide by ten: exact for positions below 1029
		row_prod = 15'(pos) * 15'd205;
		row      = row_prod[14:11];
		col_full = pos - 7'({3'b000, row} * 7'd10);
		col      = col_full[3:0];

		gap      = press ? cfg.space_debounce_us : cfg.space_release_gap_us;
		space_ok = (now_s1 >= last_space_q) && ((now_s1 - last_space_q) >= {32'b0, gap});

		rom_ch = sym_q ? symbol_char(pos) : letter_char(pos);
		if (!sym_q && caps_q && (rom_ch inside {[7'h61:7'h7A]}))
			rom_ch = rom_ch - CASE_OFFSET;

		in_map = (row < cfg.rows_in_use) && (col < cfg.cols_in_use) &&
			(row < MAP_ROWS) && (col < MAP_COLS);

		sym_d        = sym_q;
		caps_d       = caps_q;
		last_space_d = last_space_q;

		r        = '0;
		r.status = 1'b1;
		if (pending_s1 && (raw_s1 != 8'h00)) begin
			r.event_valid = 1'b1;
			r.raw_copy    = raw_s1;
			r.is_press    = press;
			r.key_code    = code;
			if (code > CODE_GPIO_MIN) begin
				r.gpio_event = 1'b1;
				r.status     = 1'b0;
			end else if (code != 7'd0) begin
				r.status          = 1'b0;
				r.matrix_position = pos;
				r.key_row         = row;
				r.key_column      = col;
				if (pos == POS_ALT) begin
					sym_d      = press;
					r.key_kind = KIND_ALT;
				end else if (pos == POS_SPACE) begin
					r.key_kind  = KIND_SPACE;
					r.character = CHAR_SPACE;
					r.is_press  = space_ok;
					if (space_ok)
						last_space_d = now_s1;
				end else if (pos == POS_CAPS) begin
					caps_d     = press;
					r.key_kind = KIND_CAPS;
				end else if (pos == POS_BACKSPACE) begin
					r.key_kind  = KIND_BACKSPACE;
					r.character = CHAR_BACKSPACE;
				end else if (in_map) begin
					r.character = rom_ch;
					if (rom_ch == CHAR_NEWLINE)
						r.key_kind = KIND_ENTER;
					else if (rom_ch == CHAR_SPACE)
						r.key_kind = KIND_SPACE;
					else if (rom_ch != 7'h00)
						r.key_kind = KIND_CHAR;
				end
			end
		end
	end

	assign res_valid = v_s1;
	assign res       = r;

`ifndef NO_ASSERTIONS
	a_space_time_only_on_space: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(last_space_q) |-> $past(adv && res.key_kind == KIND_SPACE && res.is_press))
		else $error("space timestamp moved without an emitted space beat");

	a_symbol_only_on_alt: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sym_q) |-> $past(adv && res.key_kind == KIND_ALT))
		else $error("symbol mode changed without an alt beat");

	a_caps_only_on_caps: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(caps_q) |-> $past(adv && res.key_kind == KIND_CAPS))
		else $error("caps state changed without a caps beat");
`endif

endmodule

// ===== rtl/kecd_out_reg.sv =====
module kecd_out_reg
	import kecd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  res_t       res,
	output logic       down_ready,
	kecd_res_if.source results
);

	logic valid_q;
	res_t data_q;

	assign down_ready = !valid_q | results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (down_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (down_ready && res_valid)
			data_q <= res;
	end

	assign results.valid           = valid_q;
	assign results.status          = data_q.status;
	assign results.event_valid     = data_q.event_valid;
	assign results.raw_copy        = data_q.raw_copy;
	assign results.is_press        = data_q.is_press;
	assign results.key_code        = data_q.key_code;
	assign results.gpio_event      = data_q.gpio_event;
	assign results.matrix_position = data_q.matrix_position;
	assign results.key_row         = data_q.key_row;
	assign results.key_column      = data_q.key_column;
	assign results.key_kind        = data_q.key_kind;
	assign results.character       = data_q.character;

`ifndef NO_ASSERTIONS
	a_ok_implies_event: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !data_q.status) |-> data_q.event_valid)
		else $error("ok status on a beat without an event");
`endif

endmodule

// ===== rtl/keypad_event_to_character_decoder_top.sv =====
// Channel   | Direction | Beat contents
// events    | in        | event_pending, raw_event, now_us
// results   | out       | status, event_valid, raw_copy, is_press, key_code, gpio_event,
//           |           | matrix_position, key_row, key_column, key_kind, character
// cfg       | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// An accepted events beat is registered in the input stage, then in the result register;
// one beat per cycle while results is not stalled, with the decode logic between the two.
// arst_n clears the stage valids, the alt/caps modes, the space timestamp and the config registers.
// A stall on results holds the result register and then the input stage; events.ready
// drops only when both are full.
module keypad_event_to_character_decoder_top
	import kecd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	kecd_evt_if.sink    events,
	kecd_res_if.source  results,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t cfg;
	res_t res;
	logic res_valid;
	logic down_ready;

	// Configuration registers, to be written only while the block is idle; the block does not enforce this
	kecd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input stage, mode state and the single-pass decode
	kecd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.events     (events),
		.down_ready (down_ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register: hold the beat while results stalls
	kecd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.down_ready (down_ready),
		.results    (results)
	);

endmodule

// ===== verif/keypad_event_to_character_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module keypad_event_to_character_decoder_top_tb;
	import kecd_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTING_COUNT = 8;
	localparam int EVENTS_PER_SETTING = 200;
	localparam int SETTLE_CYCLES = 6;   // input stage and result register plus margin
	localparam int HOLD_AT       = 500; // results checked before the long receiver stall
	localparam int HOLD_CYCLES   = 64;

	// Tracks the decoder state and the expected decode of every accepted event beat.
	class key_decode_scoreboard;
		// '#' marks an empty table slot
		string letter_map = "qwertyuiopasdfghjkl\n#zxcvbnm## ";
		string symbol_map = "1234567890*/+-=:'\"@##_$;?!,.## ";

		bit        symbol_mode;
		bit        caps_held;
		bit [47:0] last_space_at;
		bit [3:0]  rows_in_use;
		bit [3:0]  cols_in_use;
		bit [15:0] space_debounce_us;
		bit [15:0] space_release_gap_us;

		res_t expected_q[$];
		int   accepted;
		int   checked;
		int   mismatches;
		int   spaces_emitted;
		int   chars_emitted;

		function new();
			symbol_mode          = 1'b0;
			caps_held            = 1'b0;
			last_space_at        = '0;
			rows_in_use          = ROWS_RESET;
			cols_in_use          = COLS_RESET;
			space_debounce_us    = DEBOUNCE_RESET;
			space_release_gap_us = RELEASE_GAP_RESET;
		endfunction

		function void write_reg(cfg_index_t idx, bit [15:0] data);
			case (idx)
				CFG_ROWS:        rows_in_use = data[3:0];
				CFG_COLS:        cols_in_use = data[3:0];
				CFG_DEBOUNCE:    space_debounce_us = data;
				CFG_RELEASE_GAP: space_release_gap_us = data;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// Emit a space only when time has moved forward by at least the gap.
		function bit space_gate(bit [47:0] now, bit [15:0] gap);
			if (now < last_space_at || now - last_space_at < {32'd0, gap})
				return 1'b0;
			last_space_at = now;
			return 1'b1;
		endfunction

		function bit [6:0] table_char(bit [3:0] row, bit [3:0] col);
			string    tbl;
			int       idx;
			byte      b;
			bit [6:0] ch;
			if (row >= MAP_ROWS || col >= MAP_COLS)
				return 7'd0;
			idx = row * 10 + col;
			tbl = symbol_mode ? symbol_map : letter_map;
			if (idx >= tbl.len())
				return 7'd0;
			b = tbl[idx];
			if (b == "#")
				return 7'd0;
			ch = b[6:0];
			if (!symbol_mode && caps_held && ch >= "a" && ch <= "z")
				ch = ch - CASE_OFFSET;
			return ch;
		endfunction

		function res_t decode_key_event(bit pending, bit [7:0] raw, bit [47:0] now);
			res_t     r;
			bit       press;
			bit [6:0] code;
			bit [6:0] pos;
			r        = '0;
			r.status = 1'b1;
			if (pending && raw != 8'h00) begin
				r.event_valid = 1'b1;
				r.raw_copy    = raw;
				press         = raw[7];
				code          = raw[6:0];
				r.key_code    = code;
				if (code > CODE_GPIO_MIN) begin
					r.gpio_event = 1'b1;
					r.status     = 1'b0;
				end else if (code != 7'd0) begin
					r.status          = 1'b0;
					pos               = code - 7'd1;
					r.matrix_position = pos;
					r.key_row         = 4'(pos / 10);
					r.key_column      = 4'(pos % 10);
					if (pos == POS_ALT) begin
						symbol_mode = press;
						r.key_kind  = KIND_ALT;
					end else if (pos == POS_SPACE) begin
						r.key_kind  = KIND_SPACE;
						r.character = CHAR_SPACE;
						press = space_gate(now, press ? space_debounce_us : space_release_gap_us);
					end else if (pos == POS_CAPS) begin
						caps_held  = press;
						r.key_kind = KIND_CAPS;
					end else if (pos == POS_BACKSPACE) begin
						r.key_kind  = KIND_BACKSPACE;
						r.character = CHAR_BACKSPACE;
					end else if (r.key_row < rows_in_use && r.key_column < cols_in_use) begin
						r.character = table_char(r.key_row, r.key_column);
						if (r.character == CHAR_NEWLINE)
							r.key_kind = KIND_ENTER;
						else if (r.character == CHAR_SPACE)
							r.key_kind = KIND_SPACE;
						else if (r.character != 7'd0)
							r.key_kind = KIND_CHAR;
					end
				end
				r.is_press = press;
			end
			return r;
		endfunction

		function void note_event(bit pending, bit [7:0] raw, bit [47:0] now);
			res_t r;
			r = decode_key_event(pending, raw, now);
			if (r.key_kind == KIND_SPACE && r.is_press)
				spaces_emitted++;
			if (r.key_kind == KIND_CHAR)
				chars_emitted++;
			expected_q.push_back(r);
			accepted++;
		endfunction

		function string show(res_t r);
			return $sformatf({"st=%0d ev=%0d raw=%02h pr=%0d code=%02h gpio=%0d pos=%0d ",
				"row=%0d col=%0d kind=%0d ch=%02h"}, r.status, r.event_valid, r.raw_copy,
				r.is_press, r.key_code, r.gpio_event, r.matrix_position, r.key_row,
				r.key_column, r.key_kind, r.character);
		endfunction

		function string differing_fields(res_t e, res_t g);
			string s;
			s = "";
			if (e.status !== g.status)                   s = {s, " status"};
			if (e.event_valid !== g.event_valid)         s = {s, " event_valid"};
			if (e.raw_copy !== g.raw_copy)               s = {s, " raw_copy"};
			if (e.is_press !== g.is_press)               s = {s, " is_press"};
			if (e.key_code !== g.key_code)               s = {s, " key_code"};
			if (e.gpio_event !== g.gpio_event)           s = {s, " gpio_event"};
			if (e.matrix_position !== g.matrix_position) s = {s, " matrix_position"};
			if (e.key_row !== g.key_row)                 s = {s, " key_row"};
			if (e.key_column !== g.key_column)           s = {s, " key_column"};
			if (e.key_kind !== g.key_kind)               s = {s, " key_kind"};
			if (e.character !== g.character)             s = {s, " character"};
			return s;
		endfunction

		function void check_result(res_t got);
			res_t  want;
			string diff;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result beat: %s", show(got));
				return;
			end
			want = expected_q.pop_front();
			diff = differing_fields(want, got);
			if (diff != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result %0d differs in%s", checked, diff);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
			checked++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	kecd_evt_if evt_if ();
	kecd_res_if res_if ();

	key_decode_scoreboard sb = new();

	int        src_idle_pct;
	int        sink_idle_pct;
	int        hold_left;
	bit        hold_done;
	int        cycles;
	bit [47:0] now_t;

	keypad_event_to_character_decoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (evt_if),
		.results   (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results still expected",
				cycles, sb.outstanding());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Note every accepted event beat; sampled on the rising edge so ready and
	// valid are the values the block saw.
	always @(posedge clk) begin
		if (arst_n && evt_if.valid && evt_if.ready)
			sb.note_event(evt_if.event_pending, evt_if.raw_event, evt_if.now_us);
	end

	// Check every accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		res_t got;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready) begin
			got.status          = res_if.status;
			got.event_valid     = res_if.event_valid;
			got.raw_copy        = res_if.raw_copy;
			got.is_press        = res_if.is_press;
			got.key_code        = res_if.key_code;
			got.gpio_event      = res_if.gpio_event;
			got.matrix_position = res_if.matrix_position;
			got.key_row         = res_if.key_row;
			got.key_column      = res_if.key_column;
			got.key_kind        = res_if.key_kind;
			got.character       = res_if.character;
			sb.check_result(got);
		end
	end

	// Receiver: random back-pressure, plus one long stall once enough results
	// have gone by, so the input stage and result register both fill up and
	// the block drops events.ready while the sender keeps offering beats.
	always @(negedge clk) begin
		if (!hold_done && sb.checked >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left--;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Offer one event beat and hold it until the block takes it. Called and
	// returning at a falling edge; valid stays high for a following beat.
	task automatic send_event(bit pending, bit [7:0] raw, bit [47:0] now);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			evt_if.valid <= 1'b0;
			@(negedge clk);
		end
		evt_if.valid         <= 1'b1;
		evt_if.event_pending <= pending;
		evt_if.raw_event     <= raw;
		evt_if.now_us        <= now;
		@(posedge clk);
		while (!evt_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly plausible key traffic with a steadily advancing clock; about a
	// quarter is noise with random pending flags, raw bytes and timestamps.
	task automatic send_random_event();
		int        pick;
		bit        press;
		bit        pending;
		bit [6:0]  code;
		bit [7:0]  raw;
		bit [47:0] now;
		pick    = $urandom_range(0, 99);
		press   = 1'($urandom_range(0, 1));
		pending = 1'b1;
		now_t   = now_t + 48'((($urandom_range(0, 3) == 0) ? $urandom_range(0, 70000)
			: $urandom_range(0, 20000)));
		now     = now_t;
		if (pick < 8)
			code = POS_ALT + 7'd1;
		else if (pick < 16)
			code = POS_CAPS + 7'd1;
		else if (pick < 30)
			code = POS_SPACE + 7'd1;
		else if (pick < 34)
			code = POS_BACKSPACE + 7'd1;
		else if (pick < 70)
			code = 7'($urandom_range(1, 40));
		else if (pick < 75)
			code = 7'($urandom_range(97, 127));
		else
			code = 7'($urandom_range(0, 127));
		raw = {press, code};
		if (pick >= 75) begin
			pending = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				raw = 8'h00;
			// Keep far-off timestamps away from space so debounce keeps working.
			if ($urandom_range(0, 3) == 0 && code != POS_SPACE + 7'd1)
				now = 48'({$urandom(), $urandom()});
			else if ($urandom_range(0, 5) == 0)
				now = now_t - 48'($urandom_range(0, 30000));
		end
		send_event(pending, raw, now);
	endtask

	// Drop valid, wait for every expected result, then let the pipe settle.
	task automatic drain();
		evt_if.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Hold cfg_we high across the write; the caller lowers it.
	task automatic write_reg(cfg_index_t idx, bit [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Register setting k; the unused upper bits of the 4-bit registers get junk.
	task automatic apply_setting(int k);
		bit [3:0]  rows;
		bit [3:0]  cols;
		bit [15:0] debounce;
		bit [15:0] gap;
		case (k)
			0: begin rows = 4'd4;  cols = 4'd10; debounce = 16'd15000; gap = 16'd40000; end
			1: begin rows = 4'd1;  cols = 4'd1;  debounce = 16'd0;     gap = 16'd0;     end
			2: begin rows = 4'd8;  cols = 4'd10; debounce = 16'hFFFF;  gap = 16'hFFFF;  end
			3: begin rows = 4'd0;  cols = 4'd0;  debounce = 16'd1;     gap = 16'd1;     end
			4: begin
				rows = 4'd15; cols = 4'd15;
				debounce = 16'($urandom()); gap = 16'($urandom());
			end
			5: begin
				rows = 4'd3; cols = 4'd7;
				debounce = 16'($urandom_range(0, 30000)); gap = 16'($urandom_range(0, 65535));
			end
			6: begin
				rows = 4'($urandom_range(1, 8)); cols = 4'($urandom_range(1, 10));
				debounce = 16'd15000; gap = 16'd40000;
			end
			default: begin
				rows = 4'd4; cols = 4'd10;
				debounce = 16'($urandom()); gap = 16'($urandom());
			end
		endcase
		write_reg(CFG_ROWS, {12'($urandom()), rows});
		write_reg(CFG_COLS, {12'($urandom()), cols});
		write_reg(CFG_DEBOUNCE, debounce);
		write_reg(CFG_RELEASE_GAP, gap);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_ROWS;
		cfg_wdata            = '0;
		evt_if.valid         = 1'b0;
		evt_if.event_pending = 1'b0;
		evt_if.raw_event     = '0;
		evt_if.now_us        = '0;
		res_if.ready         = 1'b0;
		src_idle_pct         = 0;
		sink_idle_pct        = 0;
		now_t                = 48'd100000;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass under the reset register values.
		send_event(1'b0, 8'h85, 48'd100);          // empty FIFO with a stale byte
		send_event(1'b1, 8'h00, 48'd100);          // zero byte
		send_event(1'b1, 8'h80, 48'd100);          // code zero, press bit set
		send_event(1'b1, 8'h7F, 48'd100);          // top GPIO code, release
		send_event(1'b1, 8'hE1, 48'd100);          // lowest GPIO code
		send_event(1'b1, 8'hE0, 48'd100);          // last matrix code, row 9
		send_event(1'b1, 8'h81, 48'd100);          // plain letter
		send_event(1'b1, 8'h9D, 48'd100);          // caps down
		send_event(1'b1, 8'h8B, 48'd100);          // uppercased letter
		send_event(1'b1, 8'h1D, 48'd100);          // caps up
		send_event(1'b1, 8'h95, 48'd100);          // alt down: symbol table
		send_event(1'b1, 8'h81, 48'd100);          // digit
		send_event(1'b1, 8'h94, 48'd100);          // empty symbol slot
		send_event(1'b1, 8'h15, 48'd100);          // alt up
		send_event(1'b1, 8'h94, 48'd100);          // enter
		send_event(1'b1, 8'h9E, 48'd100);          // backspace
		send_event(1'b1, 8'h9F, 48'd20000);        // space press, gap met
		send_event(1'b1, 8'h9F, 48'd25000);        // space press, bounced
		send_event(1'b1, 8'h1F, 48'd70000);        // late release turns into a press
		send_event(1'b1, 8'h1F, 48'd5);            // time ran backwards
		send_event(1'b1, 8'hA8, 48'd100);          // empty letter slot
		send_event(1'b1, 8'hA9, 48'd100);          // row beyond the tables
		send_event(1'b1, 8'h96, 48'hFFFF_FFFF_FFFF);
		drain();

		// Random traffic across register settings: sender idles lightly and the
		// receiver heavily, then the reverse, then both run flat out.
		for (int k = 0; k < SETTING_COUNT; k++) begin
			if (k < 3) begin
				src_idle_pct  = 11;
				sink_idle_pct = 66;
			end else if (k < 6) begin
				src_idle_pct  = 66;
				sink_idle_pct = 11;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			apply_setting(k);
			for (int n = 0; n < EVENTS_PER_SETTING; n++)
				send_random_event();
			drain();
		end

		// Space at the far end of the time range, then a wrapped timestamp.
		send_event(1'b1, 8'h9F, 48'hFFFF_FFFF_FFFF);
		send_event(1'b1, 8'h1F, 48'hFFFF_FFFF_FFFF);
		send_event(1'b1, 8'h9F, 48'd0);
		drain();

		$display("Decoded %0d event beats over %0d register settings, %0d results checked.",
			sb.accepted, SETTING_COUNT + 1, sb.checked);
		$display("Characters emitted: %0d, space presses emitted: %0d, long stall %s.",
			sb.chars_emitted, sb.spaces_emitted, hold_done ? "applied" : "not reached");
		if (sb.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatching result beats", sb.mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== keypad_event_to_character_decoder_top.f =====
rtl/kecd_pkg.sv
rtl/kecd_evt_if.sv
rtl/kecd_res_if.sv
rtl/kecd_cfg_regs.sv
rtl/kecd_core.sv
rtl/kecd_out_reg.sv
rtl/keypad_event_to_character_decoder_top.sv
verif/keypad_event_to_character_decoder_top_tb.sv
